// ===== rtl/snh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snh_pkg
// Shared types and constants for the nonce hash pipeline.
// ----------------------------------------------------------------------------
package snh_pkg;

	// four 64-bit hash lanes, index 0 is v0
	typedef logic [3:0][63:0] lanes_t;

	localparam int unsigned LANE_W    = 64;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned NONCE_W   = 32;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 64;
	localparam int unsigned NUM_ROUND = 10;

	// register index of the magic word
	localparam logic REG_MAGIC = 1'b0;

	localparam logic [63:0] LANE_FEED_FINAL = 64'h0c00_0000_0000_0000;
	localparam logic [63:0] LANE_TWIST      = 64'h0000_0000_0000_00ff;
	localparam logic [63:0] MAGIC_RESET     = 64'h0;

endpackage

// ===== rtl/snh_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snh_round
// One SipRound with an optional word mixed into v3 before it and words
// mixed into v0 and v2 after it.
// ----------------------------------------------------------------------------
module snh_round (
	input  snh_pkg::lanes_t lane_in,
	input  logic [63:0]     pre_v3,
	input  logic [63:0]     post_v0,
	input  logic [63:0]     post_v2,
	output snh_pkg::lanes_t lane_out
);

	function automatic logic [63:0] rotl(input logic [63:0] w, input int unsigned s);
		rotl = (w << s) | (w >> (64 - s));
	endfunction

	logic [63:0] a0, a1, a2, a3;
	logic [63:0] b0, b1, b2, b3;
	logic [63:0] c0, c1, c2, c3;

	// first half round
	always_comb begin
		a0 = lane_in[0] + lane_in[1];
		a1 = rotl(lane_in[1], 13) ^ a0;
		a0 = rotl(a0, 32);
		a3 = lane_in[3] ^ pre_v3;
		a2 = lane_in[2] + a3;
		a3 = rotl(a3, 16) ^ a2;
	end

	// second half round
	always_comb begin
		b0 = a0 + a3;
		b3 = rotl(a3, 21) ^ b0;
		b2 = a2 + a1;
		b1 = rotl(a1, 17) ^ b2;
		b2 = rotl(b2, 32);
	end

	// mix in trailing words
	always_comb begin
		c0 = b0 ^ post_v0;
		c1 = b1;
		c2 = b2 ^ post_v2;
		c3 = b3;
		lane_out[0] = c0;
		lane_out[1] = c1;
		lane_out[2] = c2;
		lane_out[3] = c3;
	end

endmodule

// ===== rtl/siphash_nonce_hash_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_nonce_hash_top
// Nonce hash over a public key and timestamp with a match check.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while out_stall does not hold the pipeline,
//   one SipRound per pipeline stage (10 stages)
//   followed by a fold and compare stage that is also the output register
// stages hold their items under out_stall and empty stages fill up behind
// reset: arst_n clears all stage valid bits and sets magic_q to zero
// ----------------------------------------------------------------------------
module siphash_nonce_hash_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [snh_pkg::PADDR_W-1:0]  paddr,
	input  logic [snh_pkg::PDATA_W-1:0]  pwdata,
	output logic [snh_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// input items
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [63:0]                  key_word0,
	input  logic [63:0]                  key_word1,
	input  logic [63:0]                  key_word2,
	input  logic [63:0]                  key_word3,
	input  logic [31:0]                  stamp,
	input  logic [31:0]                  expected_nonce,
	// result items
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  nonce,
	output logic                         nonce_matches
);

	localparam int unsigned NUM_ROUND = snh_pkg::NUM_ROUND;
	localparam int unsigned LAST      = NUM_ROUND + 1;

	logic [63:0] magic_q;
	logic        cfg_wr;
	logic        cfg_idx;

	// configuration register
	assign pready  = 1'b1;
	assign cfg_idx = paddr[snh_pkg::PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= snh_pkg::MAGIC_RESET;
		end else if (cfg_wr && (cfg_idx == snh_pkg::REG_MAGIC)) begin
			magic_q <= pwdata;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			snh_pkg::REG_MAGIC: prdata = magic_q;
			default:            prdata = '0;
		endcase
	end

	// pipeline storage
	logic            vld_s [1:LAST];
	logic            rdy   [1:LAST];
	snh_pkg::lanes_t lane_s[1:NUM_ROUND];
	logic [31:0]     exp_s [1:NUM_ROUND];
	logic [31:0]     stamp_s1;
	logic [31:0]     nonce_s11;
	logic            match_s11;

	snh_pkg::lanes_t rin   [1:NUM_ROUND];
	snh_pkg::lanes_t rout  [1:NUM_ROUND];
	logic [63:0]     pre3  [1:NUM_ROUND];
	logic [63:0]     post0 [1:NUM_ROUND];
	logic [63:0]     post2 [1:NUM_ROUND];

	// stall chain: a stage loads when it is empty or its item moves on
	always_comb begin
		rdy[LAST] = !vld_s[LAST] || !out_stall;
		for (int n = LAST - 1; n >= 1; n--) begin
			rdy[n] = !vld_s[n] || rdy[n+1];
		end
	end

	assign in_stall = !rdy[1];

	// absorb schedule: stamp, magic word, final feed, then the twist
	always_comb begin
		for (int n = 1; n <= NUM_ROUND; n++) begin
			pre3[n]  = '0;
			post0[n] = '0;
			post2[n] = '0;
		end
		pre3[1]  = {32'h0, stamp};
		post0[2] = {32'h0, stamp_s1};
		pre3[3]  = magic_q;
		post0[4] = magic_q;
		pre3[5]  = snh_pkg::LANE_FEED_FINAL;
		post0[6] = snh_pkg::LANE_FEED_FINAL;
		post2[6] = snh_pkg::LANE_TWIST;
	end

	// round inputs: keys load the lanes directly
	always_comb begin
		rin[1][0] = key_word0;
		rin[1][1] = key_word1;
		rin[1][2] = key_word2;
		rin[1][3] = key_word3;
		for (int n = 2; n <= NUM_ROUND; n++) begin
			rin[n] = lane_s[n-1];
		end
	end

	for (genvar g = 1; g <= NUM_ROUND; g++) begin : g_round
		snh_round u_round (
			.lane_in (rin[g]),
			.pre_v3  (pre3[g]),
			.post_v0 (post0[g]),
			.post_v2 (post2[g]),
			.lane_out(rout[g])
		);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= LAST; n++) begin
				vld_s[n] <= 1'b0;
			end
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int n = 2; n <= LAST; n++) begin
				if (rdy[n]) begin
					vld_s[n] <= vld_s[n-1];
				end
			end
		end
	end

	// round stage payload
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			lane_s[1] <= rout[1];
			exp_s[1]  <= expected_nonce;
			stamp_s1  <= stamp;
		end
		for (int n = 2; n <= NUM_ROUND; n++) begin
			if (rdy[n]) begin
				lane_s[n] <= rout[n];
				exp_s[n]  <= exp_s[n-1];
			end
		end
	end

	// fold lanes to the nonce and compare
	logic [63:0] folded;
	logic [31:0] nonce_d;

	assign folded  = lane_s[NUM_ROUND][0] ^ lane_s[NUM_ROUND][1]
	               ^ lane_s[NUM_ROUND][2] ^ lane_s[NUM_ROUND][3];
	assign nonce_d = folded[31:0] ^ folded[63:32];

	always_ff @(posedge clk) begin
		if (rdy[LAST]) begin
			nonce_s11 <= nonce_d;
			match_s11 <= (nonce_d == exp_s[NUM_ROUND]);
		end
	end

	assign out_valid     = vld_s[LAST];
	assign nonce         = nonce_s11;
	assign nonce_matches = match_s11;

	// an accepted item lands in the first stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[1])
		else $error("accepted item did not reach the first stage");

	// a full pipeline end under stall keeps the item behind the output
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_ROUND] && vld_s[LAST] && out_stall |=> vld_s[NUM_ROUND])
		else $error("item lost behind a stalled output");

	// a magic word write takes effect
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (cfg_idx == snh_pkg::REG_MAGIC) |=> magic_q == $past(pwdata))
		else $error("magic word write not stored");

endmodule

// ===== tb/siphash_nonce_hash_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_nonce_hash_top_test
// Self-checking bench for the nonce hash pipeline. Items with directed and
// random keys, stamps and expected nonces are pushed through while both
// sides idle in several patterns. The magic word is reprogrammed between
// phases. Every result is compared against a bit-exact software hash.
// ----------------------------------------------------------------------------
module siphash_nonce_hash_top_test;

	localparam int unsigned DRAIN_CYCLES     = 24;
	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int unsigned NUM_PHASE        = 8;
	localparam int unsigned ITEMS_PER_PHASE  = 120;
	localparam logic [snh_pkg::PADDR_W-1:0] MAGIC_ADDR  =
		snh_pkg::PADDR_W'(snh_pkg::REG_MAGIC) << 3;
	localparam logic [snh_pkg::PADDR_W-1:0] UNUSED_ADDR = MAGIC_ADDR + snh_pkg::PADDR_W'(8);

	// how the expected nonce of an item relates to the true one
	typedef enum int unsigned {
		EXP_MATCH,
		EXP_FLIP,
		EXP_ZERO,
		EXP_ONES,
		EXP_RANDOM
	} exp_kind_t;

	typedef struct packed {
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [31:0] stamp;
		logic [31:0] expected_nonce;
	} hash_item_t;

	typedef struct packed {
		logic [31:0] nonce;
		logic        nonce_matches;
	} nonce_result_t;

	// software hash plus the queue of nonces still owed by the pipeline
	class nonce_scoreboard;
		logic [63:0]   magic_word;
		nonce_result_t pending[$];
		int unsigned   failures;

		function new();
			magic_word = snh_pkg::MAGIC_RESET;
			failures   = 0;
		endfunction

		function logic [63:0] rotl(logic [63:0] w, int unsigned s);
			return (w << s) | (w >> (64 - s));
		endfunction

		function void sip_rounds(inout snh_pkg::lanes_t v, input int unsigned count);
			for (int unsigned r = 0; r < count; r++) begin
				v[0] = v[0] + v[1];
				v[1] = rotl(v[1], 13);
				v[1] = v[1] ^ v[0];
				v[0] = rotl(v[0], 32);
				v[2] = v[2] + v[3];
				v[3] = rotl(v[3], 16);
				v[3] = v[3] ^ v[2];
				v[0] = v[0] + v[3];
				v[3] = rotl(v[3], 21);
				v[3] = v[3] ^ v[0];
				v[2] = v[2] + v[1];
				v[1] = rotl(v[1], 17);
				v[1] = v[1] ^ v[2];
				v[2] = rotl(v[2], 32);
			end
		endfunction

		function void absorb(inout snh_pkg::lanes_t v, input logic [63:0] word);
			v[3] = v[3] ^ word;
			sip_rounds(v, 2);
			v[0] = v[0] ^ word;
		endfunction

		function logic [31:0] compute_nonce(hash_item_t it);
			snh_pkg::lanes_t v;
			logic [63:0]     folded;
			v[0] = it.key_word0;
			v[1] = it.key_word1;
			v[2] = it.key_word2;
			v[3] = it.key_word3;
			absorb(v, {32'h0, it.stamp});
			absorb(v, magic_word);
			absorb(v, snh_pkg::LANE_FEED_FINAL);
			v[2] = v[2] ^ snh_pkg::LANE_TWIST;
			sip_rounds(v, 4);
			folded = v[0] ^ v[1] ^ v[2] ^ v[3];
			return folded[31:0] ^ folded[63:32];
		endfunction

		function void note_input(hash_item_t it);
			nonce_result_t r;
			r.nonce         = compute_nonce(it);
			r.nonce_matches = (r.nonce == it.expected_nonce);
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] got_nonce, logic got_match);
			nonce_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: nonce %h nonce_matches %b", got_nonce, got_match);
				failures++;
				return;
			end
			want = pending.pop_front();
			if (got_nonce !== want.nonce) begin
				$error("nonce: expected %h, actual %h", want.nonce, got_nonce);
				failures++;
			end
			if (got_match !== want.nonce_matches) begin
				$error("nonce_matches: expected %b, actual %b", want.nonce_matches, got_match);
				failures++;
			end
		endfunction
	endclass

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         psel           = 1'b0;
	logic                         penable        = 1'b0;
	logic                         pwrite         = 1'b0;
	logic [snh_pkg::PADDR_W-1:0]  paddr          = '0;
	logic [snh_pkg::PDATA_W-1:0]  pwdata         = '0;
	logic [snh_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	logic                         in_valid       = 1'b0;
	logic                         in_stall;
	logic [63:0]                  key_word0      = '0;
	logic [63:0]                  key_word1      = '0;
	logic [63:0]                  key_word2      = '0;
	logic [63:0]                  key_word3      = '0;
	logic [31:0]                  stamp          = '0;
	logic [31:0]                  expected_nonce = '0;
	logic                         out_valid;
	logic                         out_stall      = 1'b0;
	logic [31:0]                  nonce;
	logic                         nonce_matches;

	int unsigned         idle_pct       = 0;
	int unsigned         stall_pct      = 0;
	int unsigned         cycle_count    = 0;
	nonce_scoreboard     sb             = new();

	siphash_nonce_hash_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.key_word0      (key_word0),
		.key_word1      (key_word1),
		.key_word2      (key_word2),
		.key_word3      (key_word3),
		.stamp          (stamp),
		.expected_nonce (expected_nonce),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.nonce          (nonce),
		.nonce_matches  (nonce_matches)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("siphash_nonce_hash_top regression: fail");
			$finish;
		end
	end

	// random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input({key_word0, key_word1, key_word2, key_word3,
					stamp, expected_nonce});
			if (out_valid && !out_stall)
				sb.check_result(nonce, nonce_matches);
		end
	end

	// build an item whose expected nonce hits, nearly hits or misses
	function automatic hash_item_t make_item(logic [63:0] k0, logic [63:0] k1,
			logic [63:0] k2, logic [63:0] k3, logic [31:0] st, exp_kind_t kind);
		hash_item_t  it;
		logic [31:0] n;
		it.key_word0      = k0;
		it.key_word1      = k1;
		it.key_word2      = k2;
		it.key_word3      = k3;
		it.stamp          = st;
		it.expected_nonce = '0;
		n = sb.compute_nonce(it);
		case (kind)
			EXP_MATCH: it.expected_nonce = n;
			EXP_FLIP:  it.expected_nonce = n ^ (32'h1 << $urandom_range(31));
			EXP_ZERO:  it.expected_nonce = 32'h0;
			EXP_ONES:  it.expected_nonce = 32'hffff_ffff;
			default:   it.expected_nonce = $urandom;
		endcase
		return it;
	endfunction

	// mostly random words, with some corner values mixed in
	function automatic logic [63:0] pick_word();
		case ($urandom_range(9))
			0:       return 64'h0;
			1:       return '1;
			2:       return 64'h1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic hash_item_t random_item();
		logic [31:0] st;
		exp_kind_t   kind;
		case ($urandom_range(7))
			0:       st = 32'h0;
			1:       st = 32'hffff_ffff;
			default: st = $urandom;
		endcase
		case ($urandom_range(9))
			0, 1, 2: kind = EXP_MATCH;
			3:       kind = EXP_FLIP;
			default: kind = EXP_RANDOM;
		endcase
		return make_item(pick_word(), pick_word(), pick_word(), pick_word(), st, kind);
	endfunction

	// hold one item until the block takes it
	task automatic send_item(input hash_item_t it);
		in_valid       <= 1'b1;
		key_word0      <= it.key_word0;
		key_word1      <= it.key_word1;
		key_word2      <= it.key_word2;
		key_word3      <= it.key_word3;
		stamp          <= it.stamp;
		expected_nonce <= it.expected_nonce;
		do @(posedge clk); while (in_stall);
	endtask

	// random sender gap after an accepted item
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [snh_pkg::PADDR_W-1:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// only the magic word exists, other indexes drop the write
		if (addr == MAGIC_ADDR)
			sb.magic_word = data;
		// idle the bus before the next transfer
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [snh_pkg::PADDR_W-1:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.magic_word) begin
			$error("magic_word: expected %h, actual %h", sb.magic_word, prdata);
			sb.failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// reprogram the magic word once the pipeline is empty
	task automatic set_magic(input logic [63:0] value);
		wait_drained();
		apb_write(MAGIC_ADDR, value);
		apb_read_check(MAGIC_ADDR);
	endtask

	initial begin
		logic [63:0] magic_list [NUM_PHASE];
		magic_list[0] = '1;
		magic_list[1] = {$urandom, $urandom};
		magic_list[2] = 64'h0;
		magic_list[3] = {$urandom, $urandom};
		magic_list[4] = 64'h8000_0000_0000_0000;
		magic_list[5] = {$urandom, $urandom};
		magic_list[6] = 64'h1;
		magic_list[7] = {$urandom, $urandom};

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners with the reset magic word
		apb_read_check(MAGIC_ADDR);
		send_item(make_item('0, '0, '0, '0, 32'h0, EXP_MATCH));
		send_item(make_item('1, '1, '1, '1, 32'hffff_ffff, EXP_MATCH));
		send_item(make_item('0, '0, '0, '0, 32'hffff_ffff, EXP_FLIP));
		send_item(make_item('1, '1, '1, '1, 32'h0, EXP_RANDOM));
		send_item(make_item({4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}},
			32'haaaa_aaaa, EXP_MATCH));
		send_item(make_item({4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}},
			32'h5555_5555, EXP_FLIP));
		send_item(make_item(64'h1, '0, '0, '0, 32'h1, EXP_MATCH));
		send_item(make_item('0, '0, '0, 64'h8000_0000_0000_0000, 32'h8000_0000, EXP_MATCH));
		send_item(make_item(pick_word(), pick_word(), pick_word(), pick_word(),
			$urandom, EXP_ZERO));
		send_item(make_item(pick_word(), pick_word(), pick_word(), pick_word(),
			$urandom, EXP_ONES));

		// write to a register index that does not exist leaves the magic word alone
		wait_drained();
		apb_write(UNUSED_ADDR, '1);
		apb_read_check(MAGIC_ADDR);
		send_item(make_item('1, '0, '1, '0, 32'h1234_5678, EXP_MATCH));
		send_item(make_item('0, '1, '0, '1, 32'h8765_4321, EXP_FLIP));

		// largest magic word
		set_magic('1);
		send_item(make_item('0, '0, '0, '0, 32'h0, EXP_MATCH));
		send_item(make_item('1, '1, '1, '1, 32'hffff_ffff, EXP_MATCH));
		send_item(make_item(pick_word(), pick_word(), pick_word(), pick_word(),
			$urandom, EXP_FLIP));

		// random phases, each with its own magic word and one of four idling patterns
		for (int unsigned p = 0; p < NUM_PHASE; p++) begin
			set_magic(magic_list[p]);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
				sender_gap();
				send_item(random_item());
			end
		end

		// drain and report
		wait_drained();
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("siphash_nonce_hash_top regression: pass");
		else
			$display("siphash_nonce_hash_top regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/snh_pkg.sv
rtl/snh_round.sv
rtl/siphash_nonce_hash_top.sv
tb/siphash_nonce_hash_top_test.sv
